/* hw/rtl/assert_macros.svh */
// Assertion macros used by the framer's port-level checker in the RTL folder.
// Depends on nothing; include guarded.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* hw/rtl/upf_pkg.sv */
// Package for the UDP/IP packet framer: header constants, codes and the
// sequencer's control store. No dependencies.
package upf_pkg;

   // Frame geometry
   localparam int PAYLOAD_BYTES = 4;
   localparam int PKT_LEN       = 29 + PAYLOAD_BYTES;
   localparam int UDP_LEN       = 9 + PAYLOAD_BYTES;
   localparam int IDX_W         = $clog2(PKT_LEN);
   localparam int CNT_W         = $clog2(PAYLOAD_BYTES);

   // Header template bytes
   localparam logic [7:0] IP_VER_IHL = 8'h45;
   localparam logic [7:0] IP_FLAGS   = 8'd64;
   localparam logic [7:0] IP_TTL     = 8'd10;
   localparam logic [7:0] IP_PROTO   = 8'd17;
   localparam logic [7:0] NET_A      = 8'd172;
   localparam logic [7:0] NET_B      = 8'd26;
   localparam logic [7:0] NET_C      = 8'd79;
   localparam logic [7:0] HOST_BCAST = 8'd255;
   localparam logic [7:0] HOST_BASE  = 8'd201;
   localparam logic [7:0] PKT_LEN_B  = 8'(PKT_LEN);
   localparam logic [7:0] UDP_LEN_B  = 8'(UDP_LEN);
   // protocol + UDP length, taken modulo 256
   localparam logic [7:0] PSEUDO_PL  = 8'((17 + UDP_LEN) % 256);

   // Configuration register indexes
   localparam logic [1:0] CSR_TEAM     = 2'd0;
   localparam logic [1:0] CSR_SRC_PORT = 2'd1;
   localparam logic [1:0] CSR_DST_PORT = 2'd2;

   // Micro-ops
   localparam logic [1:0] OP_ADD      = 2'd0;  // add selected word into checksum
   localparam logic [1:0] OP_SAVE_IP  = 2'd1;  // latch IP checksum, clear sum
   localparam logic [1:0] OP_SAVE_UDP = 2'd2;  // latch UDP checksum
   localparam logic [1:0] OP_EMIT     = 2'd3;  // emit bytes, repeat until last

   // Checksum word selects
   localparam logic [4:0] W_VER_LEN  = 5'd0;
   localparam logic [4:0] W_TOT_LEN  = 5'd1;
   localparam logic [4:0] W_IDENT    = 5'd2;
   localparam logic [4:0] W_FLAGS    = 5'd3;
   localparam logic [4:0] W_TTL_PROT = 5'd4;
   localparam logic [4:0] W_SRC_HI   = 5'd5;
   localparam logic [4:0] W_SRC_LO   = 5'd6;
   localparam logic [4:0] W_DST_HI   = 5'd7;
   localparam logic [4:0] W_DST_LO   = 5'd8;
   localparam logic [4:0] W_SPORT    = 5'd9;
   localparam logic [4:0] W_DPORT    = 5'd10;
   localparam logic [4:0] W_UDP_LEN  = 5'd11;
   localparam logic [4:0] W_CTRL_P0  = 5'd12;
   localparam logic [4:0] W_P1_P2    = 5'd13;
   localparam logic [4:0] W_P3_PAD   = 5'd14;
   localparam logic [4:0] W_PSEUDO   = 5'd15;
   localparam logic [4:0] W_NONE     = 5'd16;

   typedef struct packed {
      logic [1:0] op;
      logic [4:0] sel;
   } ucode_type;

   localparam int PROG_LEN = 23;
   localparam int PC_W     = $clog2(PROG_LEN);

   // Control store: IP header sum, UDP sum, then the byte emission loop.
   function automatic ucode_type ucode(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         5'd0:  w = '{OP_ADD, W_VER_LEN};
         5'd1:  w = '{OP_ADD, W_TOT_LEN};
         5'd2:  w = '{OP_ADD, W_IDENT};
         5'd3:  w = '{OP_ADD, W_FLAGS};
         5'd4:  w = '{OP_ADD, W_TTL_PROT};
         5'd5:  w = '{OP_ADD, W_SRC_HI};
         5'd6:  w = '{OP_ADD, W_SRC_LO};
         5'd7:  w = '{OP_ADD, W_DST_HI};
         5'd8:  w = '{OP_ADD, W_DST_LO};
         5'd9:  w = '{OP_SAVE_IP, W_NONE};
         5'd10: w = '{OP_ADD, W_SPORT};
         5'd11: w = '{OP_ADD, W_DPORT};
         5'd12: w = '{OP_ADD, W_UDP_LEN};
         5'd13: w = '{OP_ADD, W_CTRL_P0};
         5'd14: w = '{OP_ADD, W_P1_P2};
         5'd15: w = '{OP_ADD, W_P3_PAD};
         5'd16: w = '{OP_ADD, W_SRC_HI};
         5'd17: w = '{OP_ADD, W_SRC_LO};
         5'd18: w = '{OP_ADD, W_DST_HI};
         5'd19: w = '{OP_ADD, W_DST_LO};
         5'd20: w = '{OP_ADD, W_PSEUDO};
         5'd21: w = '{OP_SAVE_UDP, W_NONE};
         5'd22: w = '{OP_EMIT, W_NONE};
         default: w = '{OP_EMIT, W_NONE};
      endcase
      return w;
   endfunction

endpackage

/* hw/rtl/udp_ip_packet_framer.sv */
// UDP/IP broadcast packet framer top level: payload store, microcoded
// checksum sequencer and byte emitter. Depends on upf_pkg.
//
//  channel  | ports                                     | handshake
//  ---------+-------------------------------------------+--------------------------
//  request  | start, busy, req_payload_byte             | taken when start && !busy
//  response | rsp_valid, rsp_packet_byte, rsp_last_byte | back to back, no stall
//  csr      | csr_write_enable, csr_index, csr_write_data | written when enable high
//
// Each accepted start stores one payload byte. The fourth starts a run of the
// control store: 22 checksum steps, then 33 emit steps, one byte a cycle; busy
// stays high until the last byte is emitted.
// Synchronous active-high reset clears the sequencer, counters, configuration registers and
// output strobe. The receiver cannot stall; bytes come back to back.
module udp_ip_packet_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_payload_byte,
   output logic        rsp_valid,
   output logic [7:0]  rsp_packet_byte,
   output logic        rsp_last_byte,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   // Configuration registers
   logic [3:0]  team_ff;
   logic [15:0] sport_ff;
   logic [15:0] dport_ff;

   // Payload store and fill count
   logic [7:0]                   payload_ff [upf_pkg::PAYLOAD_BYTES];
   logic [upf_pkg::CNT_W-1:0]    cnt_ff, cnt_in;

   // Sequencer state
   logic                         run_ff, run_in;
   logic [upf_pkg::PC_W-1:0]     pc_ff, pc_in;
   logic [upf_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [15:0]                  acc_ff, acc_in;
   logic [15:0]                  ip_ck_ff, ip_ck_in;
   logic [15:0]                  udp_ck_ff, udp_ck_in;

   // Output registers
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [7:0]                   rsp_byte_ff, rsp_byte_in;
   logic                         rsp_last_ff, rsp_last_in;

   upf_pkg::ucode_type           uw;
   logic                         accept;
   logic                         fill_done;
   logic                         at_last;
   logic [7:0]                   src_host;
   logic [7:0]                   ctrl_byte;
   logic [15:0]                  word;
   logic [16:0]                  sum;
   logic [15:0]                  udp_raw;
   logic [7:0]                   emit_byte;

   assign accept    = start && !run_ff;
   assign fill_done = (cnt_ff == upf_pkg::CNT_W'(upf_pkg::PAYLOAD_BYTES - 1));
   assign uw        = upf_pkg::ucode(pc_ff);
   assign at_last   = (idx_ff == upf_pkg::IDX_W'(upf_pkg::PKT_LEN - 1));
   assign src_host  = upf_pkg::HOST_BASE + {3'b000, team_ff, 1'b0};

   // Control byte: team at bits 7..4 ORed with odd parity of payload bytes at bits 4..1
   assign ctrl_byte = {team_ff[3:1],
                       team_ff[0] | ~^payload_ff[0],
                       ~^payload_ff[1],
                       ~^payload_ff[2],
                       ~^payload_ff[3],
                       1'b0};

   // Checksum word select
   always_comb begin
      case (uw.sel)
         upf_pkg::W_VER_LEN:  word = {upf_pkg::IP_VER_IHL, 8'h00};
         upf_pkg::W_TOT_LEN:  word = {8'h00, upf_pkg::PKT_LEN_B};
         upf_pkg::W_IDENT:    word = {12'h000, team_ff};
         upf_pkg::W_FLAGS:    word = {upf_pkg::IP_FLAGS, 8'h00};
         upf_pkg::W_TTL_PROT: word = {upf_pkg::IP_TTL, upf_pkg::IP_PROTO};
         upf_pkg::W_SRC_HI:   word = {upf_pkg::NET_A, upf_pkg::NET_B};
         upf_pkg::W_SRC_LO:   word = {upf_pkg::NET_C, src_host};
         upf_pkg::W_DST_HI:   word = {upf_pkg::NET_A, upf_pkg::NET_B};
         upf_pkg::W_DST_LO:   word = {upf_pkg::NET_C, upf_pkg::HOST_BCAST};
         upf_pkg::W_SPORT:    word = sport_ff;
         upf_pkg::W_DPORT:    word = dport_ff;
         upf_pkg::W_UDP_LEN:  word = {8'h00, upf_pkg::UDP_LEN_B};
         upf_pkg::W_CTRL_P0:  word = {ctrl_byte, payload_ff[0]};
         upf_pkg::W_P1_P2:    word = {payload_ff[1], payload_ff[2]};
         upf_pkg::W_P3_PAD:   word = {payload_ff[3], 8'h00};
         upf_pkg::W_PSEUDO:   word = {8'h00, upf_pkg::PSEUDO_PL};
         default:             word = 16'h0000;
      endcase
   end

   // One's-complement add with end-around carry
   assign sum     = {1'b0, acc_ff} + {1'b0, word};
   assign udp_raw = ~acc_ff;

   // Datagram byte select, wire order
   always_comb begin
      case (idx_ff)
         6'd0:    emit_byte = upf_pkg::IP_VER_IHL;
         6'd3:    emit_byte = upf_pkg::PKT_LEN_B;
         6'd5:    emit_byte = {4'h0, team_ff};
         6'd6:    emit_byte = upf_pkg::IP_FLAGS;
         6'd8:    emit_byte = upf_pkg::IP_TTL;
         6'd9:    emit_byte = upf_pkg::IP_PROTO;
         6'd10:   emit_byte = ip_ck_ff[15:8];
         6'd11:   emit_byte = ip_ck_ff[7:0];
         6'd12:   emit_byte = upf_pkg::NET_A;
         6'd13:   emit_byte = upf_pkg::NET_B;
         6'd14:   emit_byte = upf_pkg::NET_C;
         6'd15:   emit_byte = src_host;
         6'd16:   emit_byte = upf_pkg::NET_A;
         6'd17:   emit_byte = upf_pkg::NET_B;
         6'd18:   emit_byte = upf_pkg::NET_C;
         6'd19:   emit_byte = upf_pkg::HOST_BCAST;
         6'd20:   emit_byte = sport_ff[15:8];
         6'd21:   emit_byte = sport_ff[7:0];
         6'd22:   emit_byte = dport_ff[15:8];
         6'd23:   emit_byte = dport_ff[7:0];
         6'd25:   emit_byte = upf_pkg::UDP_LEN_B;
         6'd26:   emit_byte = udp_ck_ff[15:8];
         6'd27:   emit_byte = udp_ck_ff[7:0];
         6'd28:   emit_byte = ctrl_byte;
         6'd29:   emit_byte = payload_ff[0];
         6'd30:   emit_byte = payload_ff[1];
         6'd31:   emit_byte = payload_ff[2];
         6'd32:   emit_byte = payload_ff[3];
         default: emit_byte = 8'h00;
      endcase
   end

   // Sequencer next state
   always_comb begin
      cnt_in       = cnt_ff;
      run_in       = run_ff;
      pc_in        = pc_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      ip_ck_in     = ip_ck_ff;
      udp_ck_in    = udp_ck_ff;
      rsp_valid_in = 1'b0;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = 1'b0;
      if (accept) begin
         cnt_in = cnt_ff + 1'b1;
         if (fill_done) begin
            cnt_in = '0;
            run_in = 1'b1;
            pc_in  = '0;
            idx_in = '0;
            acc_in = '0;
         end
      end else if (run_ff) begin
         case (uw.op)
            upf_pkg::OP_ADD: begin
               acc_in = sum[15:0] + {15'h0000, sum[16]};
               pc_in  = pc_ff + 1'b1;
            end
            upf_pkg::OP_SAVE_IP: begin
               ip_ck_in = ~acc_ff;
               acc_in   = '0;
               pc_in    = pc_ff + 1'b1;
            end
            upf_pkg::OP_SAVE_UDP: begin
               // an all-zero UDP checksum goes out as all ones
               udp_ck_in = (udp_raw == 16'h0000) ? 16'hFFFF : udp_raw;
               pc_in     = pc_ff + 1'b1;
            end
            upf_pkg::OP_EMIT: begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = emit_byte;
               rsp_last_in  = at_last;
               idx_in       = idx_ff + 1'b1;
               // repeat this step until the final byte, then stop
               if (at_last) begin
                  run_in = 1'b0;
                  pc_in  = '0;
               end
            end
            default: begin
               pc_in = pc_ff;
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         run_ff       <= 1'b0;
         pc_ff        <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         run_ff       <= run_in;
         pc_ff        <= pc_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      ip_ck_ff    <= ip_ck_in;
      udp_ck_ff   <= udp_ck_in;
      rsp_byte_ff <= rsp_byte_in;
      if (accept) begin
         payload_ff[cnt_ff] <= req_payload_byte;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         team_ff  <= '0;
         sport_ff <= '0;
         dport_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            upf_pkg::CSR_TEAM:     team_ff  <= csr_write_data[3:0];
            upf_pkg::CSR_SRC_PORT: sport_ff <= csr_write_data;
            upf_pkg::CSR_DST_PORT: dport_ff <= csr_write_data;
            default: begin
               team_ff <= team_ff;
            end
         endcase
      end
   end

   assign busy            = run_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packet_byte = rsp_byte_ff;
   assign rsp_last_byte   = rsp_last_ff;

endmodule

/* hw/rtl/upf_checker.sv */
// Port-level checker for the UDP/IP packet framer and its bind.
// Depends on assert_macros.svh and upf_pkg.
`include "assert_macros.svh"

module upf_checker (
   input logic       clock,
   input logic       reset,
   input logic       busy,
   input logic       rsp_valid,
   input logic [7:0] rsp_packet_byte,
   input logic       rsp_last_byte
);

   // last flag only rides on a valid item
   `ASSERT_IMPLIES(a_last_valid, clock, reset, rsp_last_byte, rsp_valid)

   // mid-packet bytes come while the sequencer still runs
   `ASSERT_IMPLIES(a_mid_busy, clock, reset, rsp_valid && !rsp_last_byte, busy)

   // bytes of a packet are contiguous
   `ASSERT_NEXT(a_contig, clock, reset, rsp_valid && !rsp_last_byte, rsp_valid)

   // a gap follows every packet
   `ASSERT_NEXT(a_gap, clock, reset, rsp_last_byte, !rsp_valid)

   // every packet opens with the version/IHL byte
   `ASSERT_IMPLIES(a_first, clock, reset, $rose(rsp_valid),
                   rsp_packet_byte == upf_pkg::IP_VER_IHL)

endmodule

bind udp_ip_packet_framer upf_checker u_upf_checker (.*);
